@@ hdl/bbtp_pkg.sv @@
package bbtp_pkg;

  localparam int COORD_W  = 12;
  localparam int COLOR_W  = 8;
  localparam int CFG_IDX_W = 4;

  // Fraction bits of the reciprocal used for the gradient divide; exact for
  // box sizes below 1024 and numerators below 2**18.
  localparam int DIV_SHIFT = 28;

  localparam int DEF_BOX_WIDTH  = 140;
  localparam int DEF_BOX_HEIGHT = 140;
  localparam int DEF_STEP       = 20;

  localparam logic [COORD_W-1:0] FRAME_WIDTH_RESET  = 12'd800;
  localparam logic [COORD_W-1:0] FRAME_HEIGHT_RESET = 12'd600;
  localparam logic [COORD_W-1:0] COORD_MAX          = 12'hfff;
  localparam logic [COLOR_W-1:0] COLOR_FULL         = 8'hff;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 4'd1;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } box_state_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               last;
  } pixel_t;

endpackage

@@ hdl/bbtp_motion.sv @@
module bbtp_motion
  import bbtp_pkg::*;
#(
  parameter int BOX_WIDTH  = DEF_BOX_WIDTH,
  parameter int BOX_HEIGHT = DEF_BOX_HEIGHT,
  parameter int STEP       = DEF_STEP
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               move,
  input  logic [COORD_W-1:0] frame_width,
  input  logic [COORD_W-1:0] frame_height,
  output box_state_t         box
);

  typedef struct packed {
    logic [COORD_W-1:0] pos;
    logic               neg;
  } axis_t;

  logic  dir_x_negative;
  logic  dir_y_negative;
  axis_t axis_x_next;
  axis_t axis_y_next;

  function automatic axis_t move_axis(input logic [COORD_W-1:0] pos, input logic neg,
                                      input logic [COORD_W-1:0] box_size,
                                      input logic [COORD_W-1:0] span);
    logic [COORD_W:0]   sum;
    logic [COORD_W-1:0] p;
    logic [COORD_W+1:0] reach;
    axis_t              res;
    if (neg) begin
      p = (pos < COORD_W'(STEP)) ? '0 : pos - COORD_W'(STEP);
    end else begin
      sum = {1'b0, pos} + (COORD_W + 1)'(STEP);
      p   = sum[COORD_W] ? COORD_MAX : sum[COORD_W-1:0];
    end
    reach   = {2'b00, p} + {2'b00, box_size};
    res.pos = p;
    // flip once if either edge is reached
    res.neg = (reach >= {2'b00, span} || p == '0) ? !neg : neg;
    return res;
  endfunction

  always_comb begin
    axis_x_next = move_axis(box.x, dir_x_negative, COORD_W'(BOX_WIDTH), frame_width);
    axis_y_next = move_axis(box.y, dir_y_negative, COORD_W'(BOX_HEIGHT), frame_height);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      box            <= '0;
      dir_x_negative <= 1'b0;
      dir_y_negative <= 1'b0;
    end else if (move) begin
      box.x          <= axis_x_next.pos;
      box.y          <= axis_y_next.pos;
      dir_x_negative <= axis_x_next.neg;
      dir_y_negative <= axis_y_next.neg;
    end
  end

endmodule

@@ hdl/bbtp_shade.sv @@
module bbtp_shade
  import bbtp_pkg::*;
#(
  parameter int BOX_WIDTH  = DEF_BOX_WIDTH,
  parameter int BOX_HEIGHT = DEF_BOX_HEIGHT
) (
  input  logic [COORD_W-1:0] pixel_x,
  input  logic [COORD_W-1:0] pixel_y,
  input  logic [COORD_W-1:0] frame_width,
  input  logic [COORD_W-1:0] frame_height,
  input  box_state_t         box,
  output pixel_t             pixel
);

  localparam int DX_W = $clog2(BOX_WIDTH);
  localparam int DY_W = $clog2(BOX_HEIGHT);
  localparam int NX_W = DX_W + COLOR_W;
  localparam int NY_W = DY_W + COLOR_W;
  localparam longint unsigned RECIP_X =
    ((64'd1 << DIV_SHIFT) + 64'(BOX_WIDTH) - 64'd1) / 64'(BOX_WIDTH);
  localparam longint unsigned RECIP_Y =
    ((64'd1 << DIV_SHIFT) + 64'(BOX_HEIGHT) - 64'd1) / 64'(BOX_HEIGHT);
  localparam int RX_W = $clog2(RECIP_X + 1);
  localparam int RY_W = $clog2(RECIP_Y + 1);
  localparam int PX_W = NX_W + RX_W;
  localparam int PY_W = NY_W + RY_W;

  logic [COORD_W:0]   dx_full;
  logic [COORD_W:0]   dy_full;
  logic               in_frame;
  logic               in_box;
  logic [DX_W-1:0]    dx;
  logic [DY_W-1:0]    dy;
  logic [NX_W-1:0]    nx;
  logic [NY_W-1:0]    ny;
  logic [PX_W-1:0]    prod_x;
  logic [PY_W-1:0]    prod_y;
  logic [COLOR_W-1:0] grad_r;
  logic [COLOR_W-1:0] grad_g;
  logic [COORD_W:0]   x_plus;
  logic [COORD_W:0]   y_plus;

  always_comb begin
    in_frame = (pixel_x < frame_width) && (pixel_y < frame_height);
    dx_full  = {1'b0, pixel_x} - {1'b0, box.x};
    dy_full  = {1'b0, pixel_y} - {1'b0, box.y};
    in_box   = in_frame
             && !dx_full[COORD_W] && (dx_full[COORD_W-1:0] < COORD_W'(BOX_WIDTH))
             && !dy_full[COORD_W] && (dy_full[COORD_W-1:0] < COORD_W'(BOX_HEIGHT));
    dx       = dx_full[DX_W-1:0];
    dy       = dy_full[DY_W-1:0];
    // offset * 255 as a shift and subtract
    nx       = {dx, COLOR_W'(0)} - NX_W'(dx);
    ny       = {dy, COLOR_W'(0)} - NY_W'(dy);
    // divide by the box size through a rounded-up reciprocal
    prod_x   = PX_W'(nx) * PX_W'(RECIP_X);
    prod_y   = PY_W'(ny) * PY_W'(RECIP_Y);
    grad_r   = prod_x[DIV_SHIFT +: COLOR_W];
    grad_g   = prod_y[DIV_SHIFT +: COLOR_W];

    pixel.red   = in_box ? grad_r : COLOR_FULL;
    pixel.green = in_box ? grad_g : COLOR_FULL;
    pixel.blue  = in_box ? COLOR_FULL - grad_r : COLOR_FULL;

    x_plus      = {1'b0, pixel_x} + (COORD_W + 1)'(1);
    y_plus      = {1'b0, pixel_y} + (COORD_W + 1)'(1);
    pixel.last  = in_frame && x_plus == {1'b0, frame_width}
               && y_plus == {1'b0, frame_height};
  end

endmodule

@@ hdl/bouncing_box_test_pattern.sv @@
// Channel   Direction  Transaction             Fields (tdata / tuser / tlast)
// s_axis    in         one pixel coordinate    tdata: pixel_x, pixel_y
// m_axis    out        one RGBA pixel          tdata: red, green, blue, alpha
//                                              tlast: frame_done
// cfg       in         one register write      cfg_index, cfg_data
//
// One pixel per cycle sustained while the output is not stalled; each pixel
// passes from input to output through an input register, then the shade
// logic with its reciprocal multiply into the output register.
// rst is synchronous; it clears the valid flags, box position and directions
// and sets the frame size registers to 800 x 600.
// A stalled output holds its pixel; the input register keeps taking a new
// pixel in the cycle the output one is taken.
module bouncing_box_test_pattern
  import bbtp_pkg::*;
#(
  parameter int BOX_WIDTH  = DEF_BOX_WIDTH,
  parameter int BOX_HEIGHT = DEF_BOX_HEIGHT,
  parameter int STEP       = DEF_STEP
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [23:0]          s_tdata,    // pixel_x[11:0], pixel_y[23:12]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [31:0]          m_tdata,    // red[7:0], green[15:8], blue[23:16], alpha[31:24]
  output logic                 m_tlast,    // frame_done
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data
);

  logic [COORD_W-1:0] frame_width;
  logic [COORD_W-1:0] frame_height;
  logic               s1_valid;
  logic [COORD_W-1:0] s1_x;
  logic [COORD_W-1:0] s1_y;
  logic               advance;
  logic               done_fire;
  box_state_t         box;
  pixel_t             pixel;
  pixel_t             out_pixel;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid && (!m_tvalid || m_tready);
  assign s_tready  = !s1_valid || advance;
  assign done_fire = advance && pixel.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width  <= cfg_data;
        CFG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      s1_x <= s_tdata[11:0];
      s1_y <= s_tdata[23:12];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= s1_valid;
    end
    if (advance) begin
      out_pixel <= pixel;
    end
  end

  assign m_tdata = {COLOR_FULL, out_pixel.blue, out_pixel.green, out_pixel.red};
  assign m_tlast = out_pixel.last;

  bbtp_shade #(
    .BOX_WIDTH  (BOX_WIDTH),
    .BOX_HEIGHT (BOX_HEIGHT)
  ) u_shade (
    .pixel_x      (s1_x),
    .pixel_y      (s1_y),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .box          (box),
    .pixel        (pixel)
  );

  // advance the box as the last pixel of the frame leaves the input register
  bbtp_motion #(
    .BOX_WIDTH  (BOX_WIDTH),
    .BOX_HEIGHT (BOX_HEIGHT),
    .STEP       (STEP)
  ) u_motion (
    .clk          (clk),
    .rst          (rst),
    .move         (done_fire),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .box          (box)
  );

`ifndef SYNTHESIS
  a_blue_complements_red: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[7:0] != COLOR_FULL) |-> m_tdata[23:16] == COLOR_FULL - m_tdata[7:0])
    else $error("blue is not the complement of red inside the box");

  a_box_moves_on_done: assert property (@(posedge clk) disable iff (rst)
    !$stable(box) |-> $past(done_fire))
    else $error("box moved without a frame-done transaction");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_x) && $stable(s1_y))
    else $error("input register lost a stalled pixel");

  a_done_in_frame: assert property (@(posedge clk) disable iff (rst)
    advance && pixel.last |-> (s1_x < frame_width) && (s1_y < frame_height))
    else $error("frame done raised outside the frame");
`endif

endmodule
